### design/sha256h_pkg.sv
package sha256h_pkg;

   // Field widths of the request and response channels, and sizes of the internal state.
   localparam int DATA_W   = 8;
   localparam int WORD_W   = 32;
   localparam int INDEX_W  = 3;
   localparam int FILL_W   = 6;
   localparam int ROUND_W  = 6;
   localparam int WORDS    = 8;
   localparam int SCHED_N  = 16;
   localparam int LENGTH_W = 64;
   // Whole blocks are counted; the bit length is this count followed by fill and three zeros.
   localparam int BLOCK_CNT_W = LENGTH_W - FILL_W - 3;

   // Request operation codes.
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [DATA_W-1:0] PAD_BYTE = 8'h80;

   localparam logic [WORD_W-1:0] INIT_VEC [WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [WORD_W-1:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Round functions of the compression.
   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   // Message schedule functions.
   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

### design/sha256h_if.sv
interface sha256h_req_if;
   import sha256h_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface sha256h_rsp_if;
   import sha256h_pkg::*;

   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  digest_word;
   logic [INDEX_W-1:0] word_index;
   logic               last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

### design/sha256_hasher_core.sv
// SHA-256 over a byte stream. An append request that completes a 64-byte block is
// followed by the compression rounds and a fold of the result into the chaining words,
// and no request is taken until they are done. A finish request pads the current block
// and compresses it, or two blocks when fewer than nine bytes of room remain for the
// padding and length. The eight digest words then leave one per cycle in order while the
// receiver takes them, the eighth marked as last, and the block takes new requests once
// the last word has been taken. The single round unit performs one round a cycle
// together with one step of the message schedule.
module sha256_hasher_core (
   input logic           clock,
   input logic           reset,
   sha256h_req_if.sink   req_bus,
   sha256h_rsp_if.source rsp_bus
);
   import sha256h_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FOLD  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [BLOCK_CNT_W-1:0]  block_ff, block_in;
   logic [ROUND_W-1:0]      round_ff, round_in;
   logic [INDEX_W-1:0]      idx_ff, idx_in;
   logic                    fin_ff, fin_in;
   logic                    extra_ff, extra_in;
   logic [WORD_W-1:0]       chain_ff [WORDS];
   logic [WORD_W-1:0]       chain_in [WORDS];
   logic [WORD_W-1:0]       r_ff [WORDS];
   logic [WORD_W-1:0]       r_in [WORDS];
   logic [WORD_W-1:0]       w_ff [SCHED_N];
   logic [WORD_W-1:0]       w_in [SCHED_N];
   logic [LENGTH_W-1:0]     length_ff, length_in;

   logic [WORD_W-1:0]       t1, t2, w_next;
   logic [WORD_W-1:0]       fold_sum [WORDS];
   logic [LENGTH_W-1:0]     total_bits;
   logic                    req_fire, rsp_fire;

   assign req_fire = req_bus.valid & req_bus.ready;
   assign rsp_fire = rsp_bus.valid & rsp_bus.ready;

   // The message length is a whole number of blocks plus the bytes held now.
   assign total_bits = {block_ff, fill_ff, 3'b000};

   // One compression round, one schedule step and the fold sums.
   always_comb begin
      t1 = r_ff[7] + big_sigma1(r_ff[4]) + ((r_ff[4] & r_ff[5]) ^ (~r_ff[4] & r_ff[6]))
           + ROUND_K[round_ff] + w_ff[0];
      t2 = big_sigma0(r_ff[0])
           + ((r_ff[0] & r_ff[1]) ^ (r_ff[0] & r_ff[2]) ^ (r_ff[1] & r_ff[2]));
      w_next = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);
      for (int i = 0; i < WORDS; i++) begin
         fold_sum[i] = chain_ff[i] + r_ff[i];
      end
   end

   // Response payload comes straight from the chaining registers.
   assign rsp_bus.valid       = (state_ff == ST_OUT);
   assign rsp_bus.digest_word = chain_ff[idx_ff];
   assign rsp_bus.word_index  = idx_ff;
   assign rsp_bus.last_word   = (idx_ff == INDEX_W'(WORDS - 1));
   assign req_bus.ready       = (state_ff == ST_IDLE);

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      block_in  = block_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      fin_in    = fin_ff;
      extra_in  = extra_ff;
      length_in = length_ff;
      chain_in  = chain_ff;
      r_in      = r_ff;
      w_in      = w_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.operation == OP_APPEND) begin
                  // Byte 0 of a word sits in its top lane.
                  w_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = req_bus.data_byte;
                  fill_in = fill_ff + 1'b1;
                  if (fill_ff == '1) begin
                     block_in = block_ff + 1'b1;
                     r_in     = chain_ff;
                     state_in = ST_ROUND;
                  end
               end else begin
                  // Pad: the marker byte after the data, zeros up to the end of the block.
                  for (int j = 0; j < SCHED_N; j++) begin
                     for (int l = 0; l < 4; l++) begin
                        if (FILL_W'(4 * j + l) == fill_ff) begin
                           w_in[j][(3 - l) * 8 +: 8] = PAD_BYTE;
                        end else if (FILL_W'(4 * j + l) > fill_ff) begin
                           w_in[j][(3 - l) * 8 +: 8] = '0;
                        end
                     end
                  end
                  // The length fits in this block only if fewer than 56 bytes are held.
                  if (fill_ff[5:3] != 3'b111) begin
                     w_in[SCHED_N-2] = total_bits[LENGTH_W-1:WORD_W];
                     w_in[SCHED_N-1] = total_bits[WORD_W-1:0];
                     extra_in        = 1'b0;
                  end else begin
                     extra_in = 1'b1;
                  end
                  length_in = total_bits;
                  fin_in    = 1'b1;
                  fill_in   = '0;
                  block_in  = '0;
                  r_in      = chain_ff;
                  state_in  = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            r_in[7] = r_ff[6];
            r_in[6] = r_ff[5];
            r_in[5] = r_ff[4];
            r_in[4] = r_ff[3] + t1;
            r_in[3] = r_ff[2];
            r_in[2] = r_ff[1];
            r_in[1] = r_ff[0];
            r_in[0] = t1 + t2;
            for (int i = 0; i < SCHED_N - 1; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[SCHED_N-1] = w_next;
            round_in = round_ff + 1'b1;
            if (round_ff == '1) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in = fold_sum;
            if (extra_ff) begin
               // Second padding block: zeros and the length.
               for (int i = 0; i < SCHED_N - 2; i++) begin
                  w_in[i] = '0;
               end
               w_in[SCHED_N-2] = length_ff[LENGTH_W-1:WORD_W];
               w_in[SCHED_N-1] = length_ff[WORD_W-1:0];
               r_in     = fold_sum;
               extra_in = 1'b0;
               state_in = ST_ROUND;
            end else if (fin_ff) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == INDEX_W'(WORDS - 1)) begin
                  chain_in = INIT_VEC;
                  fin_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and chaining state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         block_ff <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         fin_ff   <= 1'b0;
         extra_ff <= 1'b0;
         chain_ff <= INIT_VEC;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         block_ff <= block_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         fin_ff   <= fin_in;
         extra_ff <= extra_in;
         chain_ff <= chain_in;
      end
   end

   // Working variables, schedule window and saved length.
   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      w_ff      <= w_in;
      length_ff <= length_in;
   end

endmodule

### design/sha256h_checker.sv
module sha256h_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_operation,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sha256h_pkg::INDEX_W-1:0] rsp_word_index,
   input logic                           rsp_last_word
);
   import sha256h_pkg::*;

   // Requests and responses never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a digest word is offered");

   // A finish request starts compression, so nothing is offered or taken next cycle.
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation == OP_FINISH) |=> (!req_ready && !rsp_valid))
      else $error("block not busy after a finish request");

   // Digest words follow each other in order.
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word)
      |=> (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words out of order");

   // The last word hands control back to the request side.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> (!rsp_valid && req_ready))
      else $error("block not idle after the last digest word");

endmodule

bind sha256_hasher_core sha256h_checker u_sha256h_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_operation  (req_bus.operation),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_word_index (rsp_bus.word_index),
   .rsp_last_word  (rsp_bus.last_word)
);
